>>> sv/mpf_pkg.sv
`default_nettype none
package mpf_pkg;

	localparam logic [1:0] REQ_PRED = 2'd0;
	localparam logic [1:0] REQ_LIST = 2'd1;
	localparam logic [1:0] REQ_ATTR = 2'd2;

	localparam logic CFG_PRED_COUNT = 1'b0;
	localparam logic CFG_SCAN_TIME  = 1'b1;

	localparam logic [2:0] OP_GT   = 3'd0;
	localparam logic [2:0] OP_LT   = 3'd1;
	localparam logic [2:0] OP_EQ   = 3'd2;
	localparam logic [2:0] OP_ALL  = 3'd3;
	localparam logic [2:0] OP_ANY  = 3'd4;
	localparam logic [2:0] OP_LIST = 3'd5;

	localparam logic [3:0] FLD_BTIME  = 4'd3;
	localparam logic [3:0] FLD_TYPE   = 4'd6;
	localparam logic [3:0] FLD_PERM   = 4'd7;
	localparam logic [3:0] FLD_LIMIT  = 4'd12;
	localparam logic [3:0] FLD_NONE   = 4'd15;

	localparam logic [3:0] ATTR_CRTIME = 4'd3;
	localparam logic [3:0] ATTR_BLOCKS = 4'd10;

	localparam logic [63:0] MODE_TYPE_MASK = 64'o170000;
	localparam logic [63:0] MODE_PERM_MASK = 64'o7777;
	localparam int BLOCK_SHIFT = 9;

	typedef enum logic [1:0] {
		CMD_PRED,
		CMD_LIST,
		CMD_ATTR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [3:0]  slot;
		logic [3:0]  field;
		logic [2:0]  op;
		logic        neg;
		logic [63:0] value;
		logic [63:0] margin;
		logic [2:0]  list_index;
		logic [3:0]  list_len;
		logic [3:0]  attr;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  field;
		logic [2:0]  op;
		logic        neg;
		logic [63:0] thr;
		logic [63:0] mar;
		logic [3:0]  list_len;
	} pred_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_PRD,
		ST_PEV,
		ST_LRD,
		ST_LEV,
		ST_FIN
	} back_state_t;

	// attribute fed by a field; type and perm both come from mode
	function automatic logic [3:0] field_attr(input logic [3:0] f);
		logic [3:0] a;
		unique case (f)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: a = f;
			4'd7, 4'd8, 4'd9, 4'd10, 4'd11:          a = f - 4'd1;
			default:                                   a = FLD_NONE;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

>>> sv/mpf_ram.sv
`default_nettype none
module mpf_ram #(
	parameter int W = 8,
	parameter int D = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> sv/mpf_front.sv
`default_nettype none
module mpf_front #(
	parameter int MAX_PREDICATES = 16,
	parameter int MAX_LIST = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic [1:0]    req_type,
	input  wire logic [3:0]    slot,
	input  wire logic [3:0]    field_code,
	input  wire logic [2:0]    op_code,
	input  wire logic          negate,
	input  wire logic [63:0]   value,
	input  wire logic [63:0]   margin,
	input  wire logic [2:0]    list_index,
	input  wire logic [3:0]    list_count,
	input  wire logic [3:0]    attr_code,
	input  wire logic          last_attr,
	output mpf_pkg::cmd_t      cmd,
	output logic               cmd_valid,
	input  wire logic          cmd_pop
);

	mpf_pkg::cmd_t buf_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	mpf_pkg::cmd_t c;
	logic          keep;
	logic          slot_ok;
	logic          idx_ok;
	logic          do_push;
	logic          do_pop;

	assign slot_ok = 32'(slot) < MAX_PREDICATES;
	assign idx_ok  = 32'(list_index) < MAX_LIST;

	always_comb begin
		c.slot       = slot;
		c.field      = field_code;
		c.op         = op_code;
		c.neg        = negate;
		c.value      = value;
		c.margin     = margin;
		c.list_index = list_index;
		c.list_len   = (32'(list_count) > MAX_LIST) ? 4'(MAX_LIST) : list_count;
		c.attr       = attr_code;
		c.last       = last_attr;
		c.kind       = mpf_pkg::CMD_ATTR;
		keep         = 1'b0;
		unique case (req_type)
			mpf_pkg::REQ_PRED: begin
				c.kind = mpf_pkg::CMD_PRED;
				keep   = slot_ok;
			end
			mpf_pkg::REQ_LIST: begin
				c.kind = mpf_pkg::CMD_LIST;
				keep   = slot_ok && idx_ok;
			end
			mpf_pkg::REQ_ATTR: begin
				c.kind = mpf_pkg::CMD_ATTR;
				keep   = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign full      = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = buf_q[rd_q];
	// rejected loads are taken and dropped here
	assign do_push   = push && !full && keep;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule
`default_nettype wire

>>> sv/mpf_back.sv
`default_nettype none
module mpf_back #(
	parameter int MAX_PREDICATES = 16,
	parameter int MAX_LIST = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  mpf_pkg::cmd_t      cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_pop,
	input  wire logic [4:0]    pred_count,
	input  wire logic [62:0]   scan_time,
	output logic               res_valid,
	output logic               res_match,
	input  wire logic          res_pop
);

	localparam int PAW = (MAX_PREDICATES > 1) ? $clog2(MAX_PREDICATES) : 1;
	localparam int LD  = MAX_PREDICATES * MAX_LIST;
	localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
	localparam int PCW = $clog2(MAX_PREDICATES + 1);
	localparam int PW  = $bits(mpf_pkg::pred_t);

	mpf_pkg::back_state_t state_q, state_d;
	mpf_pkg::cmd_t        cur_q;
	mpf_pkg::pred_t       e;
	logic [PW-1:0]        pred_rdata;
	logic [63:0]          list_rdata;
	logic [PCW-1:0]       s_q;
	logic [PCW-1:0]       n_eff;
	logic [3:0]           i_q;
	logic [63:0]          opnd_q;
	logic [63:0]          vv_q;
	logic                 neg_q;
	logic [3:0]           len_q;
	logic                 failed_q;
	logic                 res_v_q;
	logic                 res_m_q;
	logic [63:0]          age;
	logic [63:0]          vv;
	logic                 fmatch;
	logic                 to_list;
	logic                 hit;
	logic                 word_hit;
	logic                 list_done;
	logic                 can_out;
	logic [LAW-1:0]       list_waddr;
	logic [LAW-1:0]       list_raddr;
	logic                 pred_we;
	logic                 list_we;

	assign n_eff = (32'(pred_count) > MAX_PREDICATES) ? PCW'(MAX_PREDICATES)
		: PCW'(pred_count);

	assign pred_we = state_q == mpf_pkg::ST_IDLE && cmd_valid
		&& cmd.kind == mpf_pkg::CMD_PRED;
	assign list_we = state_q == mpf_pkg::ST_IDLE && cmd_valid
		&& cmd.kind == mpf_pkg::CMD_LIST;

	assign list_waddr = LAW'(cmd.slot) * LAW'(MAX_LIST) + LAW'(cmd.list_index);
	assign list_raddr = LAW'(s_q[PAW-1:0]) * LAW'(MAX_LIST) + LAW'(i_q);

	mpf_ram #(.W(PW), .D(MAX_PREDICATES), .AW(PAW)) u_pred_ram (
		.clk   (clk),
		.we    (pred_we),
		.waddr (PAW'(cmd.slot)),
		.wdata ({cmd.field, cmd.op, cmd.neg, cmd.value, cmd.margin, cmd.list_len}),
		.raddr (s_q[PAW-1:0]),
		.rdata (pred_rdata)
	);

	mpf_ram #(.W(64), .D(LD), .AW(LAW)) u_list_ram (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (cmd.value),
		.raddr (list_raddr),
		.rdata (list_rdata)
	);

	assign e = pred_rdata;

	// stamps after the scan time give age zero
	assign age = ({1'b0, scan_time} > cur_q.value) ? ({1'b0, scan_time} - cur_q.value)
		: 64'd0;

	assign fmatch = e.field < mpf_pkg::FLD_LIMIT
		&& mpf_pkg::field_attr(e.field) == cur_q.attr;
	assign vv = (e.field == mpf_pkg::FLD_PERM) ? (cur_q.value & mpf_pkg::MODE_PERM_MASK)
		: opnd_q;
	assign to_list = fmatch && e.field != mpf_pkg::FLD_TYPE && e.op == mpf_pkg::OP_LIST
		&& e.list_len != 4'd0;

	always_comb begin
		hit = 1'b0;
		if (e.field == mpf_pkg::FLD_TYPE) begin
			hit = (cur_q.value & mpf_pkg::MODE_TYPE_MASK) == e.thr;
		end else begin
			unique case (e.op)
				mpf_pkg::OP_GT:  hit = vv > e.thr;
				mpf_pkg::OP_LT:  hit = vv < e.thr;
				mpf_pkg::OP_EQ: begin
					if (e.field <= mpf_pkg::FLD_BTIME) begin
						hit = vv >= e.thr && vv < (e.thr + e.mar);
					end else if (e.mar != 64'd0) begin
						hit = vv <= e.thr && (vv + e.mar) > e.thr;
					end else begin
						hit = vv == e.thr;
					end
				end
				mpf_pkg::OP_ALL: hit = (vv & e.thr) == e.thr && (vv & e.mar) == 64'd0;
				mpf_pkg::OP_ANY: hit = (vv & e.thr) != 64'd0;
				default:         hit = 1'b0;
			endcase
		end
	end

	assign word_hit  = list_rdata == vv_q;
	assign list_done = word_hit || (i_q + 4'd1) >= len_q;
	assign can_out   = !res_v_q || res_pop;

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		unique case (state_q)
			mpf_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.kind == mpf_pkg::CMD_ATTR) begin
						state_d = mpf_pkg::ST_PREP;
					end
				end
			end
			mpf_pkg::ST_PREP: state_d = mpf_pkg::ST_PRD;
			mpf_pkg::ST_PRD: begin
				state_d = (s_q < n_eff) ? mpf_pkg::ST_PEV : mpf_pkg::ST_FIN;
			end
			mpf_pkg::ST_PEV: begin
				state_d = to_list ? mpf_pkg::ST_LRD : mpf_pkg::ST_PRD;
			end
			mpf_pkg::ST_LRD: state_d = mpf_pkg::ST_LEV;
			mpf_pkg::ST_LEV: begin
				state_d = list_done ? mpf_pkg::ST_PRD : mpf_pkg::ST_LRD;
			end
			mpf_pkg::ST_FIN: begin
				if (!cur_q.last || can_out) begin
					state_d = mpf_pkg::ST_IDLE;
				end
			end
			default: state_d = mpf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mpf_pkg::ST_IDLE && cmd_valid) begin
			cur_q <= cmd;
		end
		if (state_q == mpf_pkg::ST_PREP) begin
			if (cur_q.attr <= mpf_pkg::ATTR_CRTIME) begin
				opnd_q <= age;
			end else if (cur_q.attr == mpf_pkg::ATTR_BLOCKS) begin
				opnd_q <= cur_q.value << mpf_pkg::BLOCK_SHIFT;
			end else begin
				opnd_q <= cur_q.value;
			end
		end
		if (state_q == mpf_pkg::ST_PEV) begin
			vv_q  <= vv;
			neg_q <= e.neg;
			len_q <= e.list_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q      <= '0;
			i_q      <= '0;
			failed_q <= 1'b0;
			res_v_q  <= 1'b0;
			res_m_q  <= 1'b0;
		end else begin
			// a new verdict may replace the one leaving in the same cycle
			if (state_q == mpf_pkg::ST_FIN && cur_q.last && can_out) begin
				res_v_q <= 1'b1;
			end else if (res_pop && res_v_q) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				mpf_pkg::ST_PREP: s_q <= '0;
				mpf_pkg::ST_PEV: begin
					i_q <= '0;
					if (!to_list) begin
						s_q <= s_q + PCW'(1);
						if (fmatch && hit == e.neg) begin
							failed_q <= 1'b1;
						end
					end
				end
				mpf_pkg::ST_LEV: begin
					i_q <= i_q + 4'd1;
					if (list_done) begin
						s_q <= s_q + PCW'(1);
						if (word_hit == neg_q) begin
							failed_q <= 1'b1;
						end
					end
				end
				mpf_pkg::ST_FIN: begin
					if (cur_q.last && can_out) begin
						res_m_q  <= !failed_q;
						failed_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign res_valid = res_v_q;
	assign res_match = res_m_q;

endmodule
`default_nettype wire

>>> sv/metadata_predicate_filter.sv
// channel   direction  handshake             payload
// input     in         push / full           req_type .. last_attr
// result    out        pop / empty           match
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A load item is written to its table as it is popped. An attribute visits each active
// predicate, and each list word scanned (up to the first hit) for list predicates: the
// predicate and list RAMs each give one registered read through one comparator.
// Reset clears control state only; the tables hold nothing until loaded.
// A two-entry queue lets input run ahead; a held result stalls the back end at the
// verdict of the next record.
`default_nettype none
module metadata_predicate_filter #(
	parameter int MAX_PREDICATES = 16,
	parameter int MAX_LIST = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  req_type,
	input  wire logic [3:0]  slot,
	input  wire logic [3:0]  field_code,
	input  wire logic [2:0]  op_code,
	input  wire logic        negate,
	input  wire logic [63:0] value,
	input  wire logic [63:0] margin,
	input  wire logic [2:0]  list_index,
	input  wire logic [3:0]  list_count,
	input  wire logic [3:0]  attr_code,
	input  wire logic        last_attr,
	output logic             empty,
	input  wire logic        pop,
	output logic             match,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data
);

	mpf_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_pop;
	logic [4:0]    pred_count_q;
	logic [62:0]   scan_time_q;
	logic          res_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_count_q <= '0;
			scan_time_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mpf_pkg::CFG_PRED_COUNT: pred_count_q <= cfg_data[4:0];
				mpf_pkg::CFG_SCAN_TIME:  scan_time_q  <= cfg_data[62:0];
				default: ;
			endcase
		end
	end

	mpf_front #(.MAX_PREDICATES(MAX_PREDICATES), .MAX_LIST(MAX_LIST)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.slot       (slot),
		.field_code (field_code),
		.op_code    (op_code),
		.negate     (negate),
		.value      (value),
		.margin     (margin),
		.list_index (list_index),
		.list_count (list_count),
		.attr_code  (attr_code),
		.last_attr  (last_attr),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop)
	);

	mpf_back #(.MAX_PREDICATES(MAX_PREDICATES), .MAX_LIST(MAX_LIST)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.pred_count (pred_count_q),
		.scan_time  (scan_time_q),
		.res_valid  (res_valid),
		.res_match  (match),
		.res_pop    (pop)
	);

	assign empty = !res_valid;

endmodule
`default_nettype wire

>>> sv/mpf_checker.sv
`default_nettype none
module mpf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input wire logic match,
	input wire logic cfg_ready
);

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

	a_reset_state: assert property (@(posedge clk) $rose(arst_n) |-> empty && !full)
		else $error("queues not empty after reset");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(match))
		else $error("waiting result dropped or changed");

endmodule

bind metadata_predicate_filter mpf_checker u_mpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.match     (match),
	.cfg_ready (cfg_ready)
);
`default_nettype wire
